### src/efd_pkg.sv
package efd_pkg;

   localparam int HDR_BYTES   = 28;
   localparam int TYPE_OFFSET = 4;
   localparam int ID_OFFSET   = 8;
   localparam int STAMP_OFFSET = 16;
   localparam int LEN_OFFSET  = 24;

   localparam int IDX_W  = 5;
   localparam int BYTE_W = 8;
   localparam int REG_W  = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_HEADER      = 2'd0,
      KIND_PAYLOAD     = 2'd1,
      KIND_BAD_VERSION = 2'd2,
      KIND_OVERSIZE    = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_EXPECTED_VERSION = 1'b0,
      CSR_MAX_PAYLOAD      = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type          kind;
      logic [31:0]       msg_type;
      logic [63:0]       ev_ident;
      logic [63:0]       stamp_ms;
      logic [31:0]       payload_length;
      logic [BYTE_W-1:0] data_out;
      logic              last;
   } result_type;

endpackage

### src/efd_parse.sv
module efd_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [efd_pkg::BYTE_W-1:0] req_tdata,
   input  logic [efd_pkg::REG_W-1:0]  expected_version,
   input  logic [efd_pkg::REG_W-1:0]  max_payload,
   input  logic                       slot_free,
   output logic                       res_valid,
   output efd_pkg::result_type        res
);
   import efd_pkg::*;

   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic             in_payload_ff, in_payload_in;
   logic [31:0]      hdr_version_ff, hdr_version_in;
   logic [31:0]      hdr_type_ff, hdr_type_in;
   logic [63:0]      hdr_ev_ident_ff, hdr_ev_ident_in;
   logic [63:0]      hdr_timestamp_ff, hdr_timestamp_in;
   logic [31:0]      hdr_length_ff, hdr_length_in;
   logic [31:0]      payload_left_ff, payload_left_in;

   logic             has_res;
   logic             fire;
   logic [IDX_W-1:0] idx;
   logic [BYTE_W-1:0] b;

   assign fire       = in_vld_ff && (!has_res || slot_free);
   assign req_tready = !in_vld_ff || fire;
   assign res_valid  = in_vld_ff && has_res;

   always_comb begin
      b                = in_byte_ff;
      byte_index_in    = byte_index_ff;
      in_payload_in    = in_payload_ff;
      hdr_version_in   = hdr_version_ff;
      hdr_type_in      = hdr_type_ff;
      hdr_ev_ident_in  = hdr_ev_ident_ff;
      hdr_timestamp_in = hdr_timestamp_ff;
      hdr_length_in    = hdr_length_ff;
      payload_left_in  = payload_left_ff;
      has_res          = 1'b0;
      idx              = (byte_index_ff > LAST_IDX) ? LAST_IDX : byte_index_ff;
      res.kind         = KIND_HEADER;
      res.data_out     = '0;
      res.last         = 1'b0;

      if (in_payload_ff && payload_left_ff != '0) begin
         payload_left_in = payload_left_ff - 32'd1;
         has_res         = 1'b1;
         res.kind        = KIND_PAYLOAD;
         res.data_out    = b;
         res.last        = (payload_left_ff == 32'd1);
         if (payload_left_ff == 32'd1) begin
            in_payload_in = 1'b0;
         end
      end else begin
         in_payload_in = 1'b0;
         priority if (idx < IDX_W'(TYPE_OFFSET)) begin
            hdr_version_in[idx[1:0]*8 +: 8] = b;
         end else if (idx < IDX_W'(ID_OFFSET)) begin
            hdr_type_in[idx[1:0]*8 +: 8] = b;
         end else if (idx < IDX_W'(STAMP_OFFSET)) begin
            hdr_ev_ident_in[idx[2:0]*8 +: 8] = b;
         end else if (idx < IDX_W'(LEN_OFFSET)) begin
            hdr_timestamp_in[idx[2:0]*8 +: 8] = b;
         end else begin
            hdr_length_in[idx[1:0]*8 +: 8] = b;
         end

         if (idx != LAST_IDX) begin
            byte_index_in = idx + IDX_W'(1);
         end else begin
            byte_index_in = '0;
            has_res       = 1'b1;
            // oversize wins over the version check
            priority if (hdr_length_in > max_payload) begin
               res.kind = KIND_OVERSIZE;
               res.last = 1'b1;
            end else if (hdr_version_in != expected_version) begin
               res.kind = KIND_BAD_VERSION;
               res.last = 1'b1;
            end else begin
               res.kind = KIND_HEADER;
               res.last = (hdr_length_in == '0);
               if (hdr_length_in != '0) begin
                  in_payload_in   = 1'b1;
                  payload_left_in = hdr_length_in;
               end
            end
         end
      end

      res.msg_type       = hdr_type_in;
      res.ev_ident       = hdr_ev_ident_in;
      res.stamp_ms       = hdr_timestamp_in;
      res.payload_length = hdr_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         byte_index_ff    <= '0;
         in_payload_ff    <= 1'b0;
         payload_left_ff  <= '0;
         hdr_version_ff   <= '0;
         hdr_type_ff      <= '0;
         hdr_ev_ident_ff  <= '0;
         hdr_timestamp_ff <= '0;
         hdr_length_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (fire) begin
            byte_index_ff    <= byte_index_in;
            in_payload_ff    <= in_payload_in;
            payload_left_ff  <= payload_left_in;
            hdr_version_ff   <= hdr_version_in;
            hdr_type_ff      <= hdr_type_in;
            hdr_ev_ident_ff  <= hdr_ev_ident_in;
            hdr_timestamp_ff <= hdr_timestamp_in;
            hdr_length_ff    <= hdr_length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= LAST_IDX)
      else $error("header byte index beyond the header");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> payload_left_ff != '0)
      else $error("payload state with no bytes left");

   a_final_byte_last: assert property (@(posedge clock) disable iff (reset)
      fire && in_payload_ff && payload_left_ff == 32'd1 |-> res_valid && res.last)
      else $error("final payload byte not marked last");

   a_error_resync: assert property (@(posedge clock) disable iff (reset)
      fire && res_valid && (res.kind == KIND_OVERSIZE || res.kind == KIND_BAD_VERSION)
      |=> byte_index_ff == '0 && !in_payload_ff)
      else $error("no resync to header after an error");

endmodule

### src/efd_out.sv
module efd_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  efd_pkg::result_type res,
   output logic                slot_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [199:0]        rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import efd_pkg::*;

   logic       out_vld_ff;
   result_type out_res_ff;
   logic       load;

   assign slot_free = !out_vld_ff || rsp_tready;
   assign load      = res_valid && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tlast  = out_res_ff.last;
   assign rsp_tdata  = {out_res_ff.data_out, out_res_ff.payload_length,
                        out_res_ff.stamp_ms, out_res_ff.ev_ident, out_res_ff.msg_type};

endmodule

### src/event_frame_deframer.sv
// Length-prefixed event frame deframer. Takes one stream byte per clock and
// collects a 28-byte little-endian header (version, type, event id, timestamp,
// payload length). On the last header byte it returns one response: oversize
// when the length exceeds max_payload (checked first), bad version when the
// version differs from expected_version, or a header response followed by one
// response per payload byte, tlast on the final byte (or on the header
// response itself for an empty payload). After an error, the next byte starts a
// new header. Throughput is one byte per clock while responses do not stall;
// a response passes one input register and one output register, and only a
// stalled response side slows the request side. Configuration is written
// through the csr_ port; the user must write it only while no request is in flight, as the block does not enforce it.
module event_frame_deframer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_in[7:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // msg_type[31:0], ev_ident[95:32], stamp_ms[159:96],
   // payload_length[191:160], data_out[199:192]
   output logic [199:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // kind[1:0]
   output logic         rsp_tlast,   // last
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   import efd_pkg::*;

   logic [REG_W-1:0] expected_version_ff;
   logic [REG_W-1:0] max_payload_ff;
   logic             slot_free;
   logic             res_valid;
   result_type       res;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= 32'd1;
         max_payload_ff      <= 32'd1048576;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata;
            CSR_MAX_PAYLOAD:      max_payload_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   efd_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .expected_version (expected_version_ff),
      .max_payload      (max_payload_ff),
      .slot_free        (slot_free),
      .res_valid        (res_valid),
      .res              (res)
   );

   efd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### verif/efd_frame_checker.sv
module efd_frame_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [199:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);
   import efd_pkg::*;

   result_type        due_results[$];
   logic [31:0]       want_version = 32'd1;
   logic [31:0]       max_len      = 32'd1048576;
   logic [IDX_W-1:0]  hdr_pos      = '0;
   logic              in_body      = 1'b0;
   logic [31:0]       hdr_ver      = '0;
   logic [31:0]       hdr_type     = '0;
   logic [63:0]       hdr_id       = '0;
   logic [63:0]       hdr_stamp    = '0;
   logic [31:0]       hdr_len      = '0;
   logic [31:0]       body_left    = '0;

   function automatic result_type frame_result(kind_type k, logic [7:0] d, logic l);
      result_type r;
      r.kind           = k;
      r.msg_type       = hdr_type;
      r.ev_ident       = hdr_id;
      r.stamp_ms       = hdr_stamp;
      r.payload_length = hdr_len;
      r.data_out       = d;
      r.last           = l;
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      int idx;
      if (in_body && body_left != 0) begin
         body_left = body_left - 32'd1;
         due_results.insert(due_results.size(), frame_result(KIND_PAYLOAD, b, body_left == 0));
         if (body_left == 0) begin
            in_body = 1'b0;
         end
         return;
      end
      in_body = 1'b0;
      idx = (int'(hdr_pos) >= HDR_BYTES) ? HDR_BYTES - 1 : int'(hdr_pos);
      // little-endian fill of the header fields
      if (idx < TYPE_OFFSET) begin
         hdr_ver[idx*8 +: 8] = b;
      end else if (idx < ID_OFFSET) begin
         hdr_type[(idx-TYPE_OFFSET)*8 +: 8] = b;
      end else if (idx < STAMP_OFFSET) begin
         hdr_id[(idx-ID_OFFSET)*8 +: 8] = b;
      end else if (idx < LEN_OFFSET) begin
         hdr_stamp[(idx-STAMP_OFFSET)*8 +: 8] = b;
      end else begin
         hdr_len[(idx-LEN_OFFSET)*8 +: 8] = b;
      end
      if (idx < HDR_BYTES - 1) begin
         hdr_pos = IDX_W'(idx + 1);
         return;
      end
      hdr_pos = '0;
      // oversize takes priority over a version mismatch
      if (hdr_len > max_len) begin
         due_results.insert(due_results.size(), frame_result(KIND_OVERSIZE, 8'd0, 1'b1));
      end else if (hdr_ver != want_version) begin
         due_results.insert(due_results.size(), frame_result(KIND_BAD_VERSION, 8'd0, 1'b1));
      end else if (hdr_len == 0) begin
         due_results.insert(due_results.size(), frame_result(KIND_HEADER, 8'd0, 1'b1));
      end else begin
         due_results.insert(due_results.size(), frame_result(KIND_HEADER, 8'd0, 1'b0));
         in_body   = 1'b1;
         body_left = hdr_len;
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         want_version = 32'd1;
         max_len      = 32'd1048576;
         hdr_pos      = '0;
         in_body      = 1'b0;
         hdr_ver      = '0;
         hdr_type     = '0;
         hdr_id       = '0;
         hdr_stamp    = '0;
         hdr_len      = '0;
         body_left    = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_EXPECTED_VERSION) begin
               want_version = csr_wdata;
            end else begin
               max_len = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.kind           = kind_type'(rsp_tuser);
            seen.msg_type       = rsp_tdata[31:0];
            seen.ev_ident       = rsp_tdata[95:32];
            seen.stamp_ms       = rsp_tdata[159:96];
            seen.payload_length = rsp_tdata[191:160];
            seen.data_out       = rsp_tdata[199:192];
            seen.last           = rsp_tlast;
            if (due_results.size() == 0) begin
               $error("response with nothing outstanding: kind %0d", rsp_tuser);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, seen.kind);
               check_field("msg_type", want.msg_type, seen.msg_type);
               check_field("ev_ident", want.ev_ident, seen.ev_ident);
               check_field("stamp_ms", want.stamp_ms, seen.stamp_ms);
               check_field("payload_length", want.payload_length, seen.payload_length);
               check_field("data_out", want.data_out, seen.data_out);
               check_field("last", want.last, seen.last);
            end
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
         end
      end
      pending = due_results.size();
   end

endmodule

### verif/tb_event_frame_deframer.sv
module tb_event_frame_deframer;
   import efd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 80;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we     = 1'b0;
   logic         csr_index  = CSR_EXPECTED_VERSION;
   logic [31:0]  csr_wdata  = '0;

   int           chk_failures;
   int           chk_pending;
   int           cycle_count = 0;
   bit           hold_req    = 1'b0;
   logic [7:0]   byte_stream[$];
   logic [31:0]  cur_version = 32'd1;
   logic [31:0]  cur_max     = 32'd1048576;

   always #5 clock = ~clock;

   event_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   efd_frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (chk_failures),
      .pending    (chk_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** event_frame_deframer: FAILED **");
         $finish;
      end
   end

   // response side: random stall pattern, redrawn after each run of random length
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            // hold off long enough for the block to back up into the request side
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic queue_frame(logic [31:0] ver, logic [31:0] mtype, logic [63:0] id,
                              logic [63:0] stamp, logic [31:0] len);
      for (int i = 0; i < 4; i++) byte_stream.insert(byte_stream.size(), ver[i*8 +: 8]);
      for (int i = 0; i < 4; i++) byte_stream.insert(byte_stream.size(), mtype[i*8 +: 8]);
      for (int i = 0; i < 8; i++) byte_stream.insert(byte_stream.size(), id[i*8 +: 8]);
      for (int i = 0; i < 8; i++) byte_stream.insert(byte_stream.size(), stamp[i*8 +: 8]);
      for (int i = 0; i < 4; i++) byte_stream.insert(byte_stream.size(), len[i*8 +: 8]);
      // payload only follows an accepted header
      if (len <= cur_max && ver == cur_version) begin
         repeat (len) byte_stream.insert(byte_stream.size(), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_frame();
      int          pick;
      logic [31:0] ver;
      logic [31:0] len;
      logic [31:0] cap;
      pick = $urandom_range(0, 9);
      cap  = (cur_max < 32'd12) ? cur_max : 32'd12;
      ver  = cur_version;
      len  = $urandom_range(0, cap);
      if (pick == 7) begin
         ver = cur_version ^ (32'd1 << $urandom_range(0, 31));
         if ($urandom_range(0, 1) == 1) len = $urandom;
      end else if (pick == 8) begin
         if (cur_max != 32'hFFFF_FFFF) len = $urandom_range(cur_max + 32'd1, 32'hFFFF_FFFF);
         if ($urandom_range(0, 1) == 1) ver = $urandom;
      end else if (pick == 9) begin
         // noise header; never let it open a long payload
         ver = $urandom;
         len = $urandom;
         if (ver == cur_version && len > cap) ver = ~ver;
      end
      queue_frame(ver, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, len);
   endtask

   task automatic send_stream();
      int burst;
      int gap;
      while (byte_stream.size() != 0) begin
         burst = $urandom_range(1, 40);
         gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         while (burst != 0 && byte_stream.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_stream.pop_front();
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            burst--;
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (chk_pending != 0) @(posedge clock);
      // trailing header bytes give no response but may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] ver, logic [31:0] max);
      csr_we    <= 1'b1;
      csr_index <= CSR_EXPECTED_VERSION;
      csr_wdata <= ver;
      @(posedge clock);
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= max;
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_version = ver;
      cur_max     = max;
   endtask

   initial begin
      logic [31:0] phase_ver[4];
      logic [31:0] phase_max[4];
      phase_ver = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom};
      phase_max = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 20)), 32'd6};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset settings
      queue_frame(32'd1, '0, '0, '0, 32'd0);
      queue_frame(32'd1, '1, '1, '1, 32'd1);
      queue_frame(32'd1, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd3);
      queue_frame(32'd2, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, 32'd5);
      queue_frame(32'd0, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, 32'd2);
      queue_frame(32'd1, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, 32'd1048577);
      queue_frame(32'd0, '1, '1, '1, 32'hFFFF_FFFF);
      queue_frame(32'hFFFF_FFFF, '0, '0, '0, 32'd1048576);
      send_stream();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         set_config(phase_ver[ph], phase_max[ph]);
         if (cur_max < 32'd64) begin
            queue_frame(cur_version, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                        cur_max);
            queue_frame(cur_version, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                        cur_max + 32'd1);
         end else begin
            queue_frame(cur_version, '1, '1, '1, 32'd4);
            queue_frame(~cur_version, '0, '0, '0, 32'hFFFF_FFFF);
         end
         while (byte_stream.size() < PHASE_BYTES) random_frame();
         if (ph == 2) hold_req = 1'b1;
         send_stream();
         drain();
      end

      if (chk_failures == 0) begin
         $display("** event_frame_deframer: PASSED **");
      end else begin
         $display("** event_frame_deframer: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
src/efd_pkg.sv
src/efd_parse.sv
src/efd_out.sv
src/event_frame_deframer.sv
verif/efd_frame_checker.sv
verif/tb_event_frame_deframer.sv
